// File: rtl/agpid_pkg.sv
// ---------------------------------------------------------------------------
// agpid_pkg
// Shared constants, register indexes and the microcode table of the
// asymmetric-gain PID controller.
// ---------------------------------------------------------------------------
`default_nettype none

package agpid_pkg;

  localparam int ERROR_WIDTH_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int GAIN_W             = 16;
  localparam int CFG_AW             = 3;
  localparam int STEP_W             = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN_P_NONNEG = 3'd0,
    REG_GAIN_P_NEG    = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_GAIN_I        = 3'd3,
    REG_DRIVE_OFFSET  = 3'd4
  } reg_idx_t;

  // multiplier operand selects
  typedef enum logic [1:0] {
    A_KP = 2'd0,
    A_GD = 2'd1,
    A_GI = 2'd2
  } a_sel_t;

  typedef enum logic [1:0] {
    B_ERR  = 2'd0,
    B_DIFF = 2'd1,
    B_DIN  = 2'd2,
    B_SUM  = 2'd3
  } b_sel_t;

  // sequencing: advance, or hold the step until a handshake is possible
  typedef enum logic [1:0] {
    J_NEXT     = 2'd0,
    J_WAIT_IN  = 2'd1,
    J_WAIT_OUT = 2'd2
  } jmp_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   mul_en;
    logic   acc_add;
    logic   din_load;
    logic   take_in;
    logic   emit;
    jmp_t   jmp;
  } ctl_t;

  // control store: one word per step, wraps from the last step to step 0
  function automatic ctl_t prog_rom(input logic [STEP_W-1:0] step);
    ctl_t c;
    c = '{a_sel: A_KP, b_sel: B_ERR, mul_en: 1'b0, acc_add: 1'b0,
          din_load: 1'b0, take_in: 1'b0, emit: 1'b0, jmp: J_NEXT};
    case (step)
      3'd0: begin
        c.take_in = 1'b1;
        c.jmp     = J_WAIT_IN;
      end
      3'd1: begin
        c.mul_en = 1'b1;
        c.a_sel  = A_KP;
        c.b_sel  = B_ERR;
      end
      3'd2: begin
        c.acc_add = 1'b1;
        c.mul_en  = 1'b1;
        c.a_sel   = A_GD;
        c.b_sel   = B_DIFF;
      end
      3'd3: begin
        c.din_load = 1'b1;
      end
      3'd4: begin
        c.mul_en = 1'b1;
        c.a_sel  = A_KP;
        c.b_sel  = B_DIN;
      end
      3'd5: begin
        c.acc_add = 1'b1;
        c.mul_en  = 1'b1;
        c.a_sel   = A_GI;
        c.b_sel   = B_SUM;
      end
      3'd6: begin
        c.acc_add = 1'b1;
      end
      3'd7: begin
        c.emit = 1'b1;
        c.jmp  = J_WAIT_OUT;
      end
      default: begin
        c.jmp = J_NEXT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/asymmetric_gain_pid_controller.sv
// ---------------------------------------------------------------------------
// asymmetric_gain_pid_controller
// PID controller with a sign-dependent proportional gain, run by a small
// microcode sequencer around one shared signed multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one error sample per word (in_tdata low ERROR_WIDTH bits).
//   out_* : one drive word per input word; out_tuser flags saturation of
//           the error sum or the drive during that step.
//   cfg_* : write gains and offset while the block is idle.
// Sequence: an 8-step program. Step 0 takes the input word, steps 1..6 run
//   four products through the single multiplier (kp*e, kd*diff,
//   kp*dinner, ki*sum) and accumulate, step 7 saturates and loads the
//   output register. A new input word is taken only once the previous
//   result has been loaded into the output register.
// The output register lets a new input be taken while a result waits;
//   if the receiver stalls, the sequencer holds in step 7 until the
//   output register frees up, then input is taken again.
// Reset clears the gains, offset, previous error, error sum and the
//   output valid; the sequencer restarts at step 0.
// ---------------------------------------------------------------------------
`default_nettype none

module asymmetric_gain_pid_controller #(
  parameter int ERROR_WIDTH    = agpid_pkg::ERROR_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = agpid_pkg::GAIN_FRAC_BITS_DEF,
  localparam int IN_TW         = ((ERROR_WIDTH + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: [ERROR_WIDTH-1:0] error_sample, rest zero
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [IN_TW-1:0]              in_tdata,
  // out_tdata: [31:0] drive_value
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [31:0]                        out_tdata,
  // out_tuser: [0] clipped
  output logic                               out_tuser,
  input  wire logic                          cfg_we,
  input  wire logic [agpid_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [agpid_pkg::GAIN_W-1:0]  cfg_wdata
);

  localparam int EW     = ERROR_WIDTH;
  localparam int GW     = agpid_pkg::GAIN_W;
  localparam int B_W    = (EW + GW + 1 > 33) ? (EW + GW + 1) : 33;
  localparam int PROD_W = GW + B_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SUM_W  = ((EW > 32) ? EW : 32) + 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-32){1'b0}}, 32'h7fff_ffff};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-32){1'b1}}, 32'h8000_0000};

  // configuration
  logic signed [GW-1:0] gain_pp_r, gain_pn_r, gain_d_r, gain_i_r, offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_pp_r <= '0;
      gain_pn_r <= '0;
      gain_d_r  <= '0;
      gain_i_r  <= '0;
      offset_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        agpid_pkg::REG_GAIN_P_NONNEG: gain_pp_r <= cfg_wdata;
        agpid_pkg::REG_GAIN_P_NEG:    gain_pn_r <= cfg_wdata;
        agpid_pkg::REG_GAIN_D:        gain_d_r  <= cfg_wdata;
        agpid_pkg::REG_GAIN_I:        gain_i_r  <= cfg_wdata;
        agpid_pkg::REG_DRIVE_OFFSET:  offset_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  logic [agpid_pkg::STEP_W-1:0] step_r, step_nxt;
  agpid_pkg::ctl_t              ctl;
  logic                         in_fire, out_free;

  assign ctl       = agpid_pkg::prog_rom(step_r);
  assign in_tready = ctl.take_in;
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid | out_tready;

  always_comb begin
    step_nxt = step_r + 1'b1;
    case (ctl.jmp)
      agpid_pkg::J_NEXT:     step_nxt = step_r + 1'b1;
      agpid_pkg::J_WAIT_IN:  if (!in_fire) step_nxt = step_r;
      agpid_pkg::J_WAIT_OUT: if (!out_free) step_nxt = step_r;
      default:               step_nxt = step_r + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  // datapath state
  logic signed [EW-1:0]    err_r, prev_r;
  logic signed [EW:0]      diff_r;
  logic signed [31:0]      sum_r;
  logic                    hit_r;
  logic signed [B_W-1:0]   din_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [EW-1:0]    err_in;
  logic signed [SUM_W-1:0] sum_wide;
  logic                    sum_ovf;
  logic signed [31:0]      sum_sat;
  logic signed [GW-1:0]    kp, op_a;
  logic signed [B_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod_sh;
  logic                    acc_hi, acc_lo;

  assign err_in   = in_tdata[EW-1:0];
  assign sum_wide = {{(SUM_W-32){sum_r[31]}}, sum_r} + {{(SUM_W-EW){err_in[EW-1]}}, err_in};
  assign sum_ovf  = (sum_wide > $signed({{(SUM_W-32){1'b0}}, 32'h7fff_ffff})) ||
                    (sum_wide < $signed({{(SUM_W-32){1'b1}}, 32'h8000_0000}));

  always_comb begin
    sum_sat = sum_wide[31:0];
    if (sum_ovf) begin
      sum_sat = sum_wide[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign kp = err_r[EW-1] ? gain_pn_r : gain_pp_r;

  always_comb begin
    case (ctl.a_sel)
      agpid_pkg::A_KP: op_a = kp;
      agpid_pkg::A_GD: op_a = gain_d_r;
      agpid_pkg::A_GI: op_a = gain_i_r;
      default:         op_a = kp;
    endcase
    case (ctl.b_sel)
      agpid_pkg::B_ERR:  op_b = {{(B_W-EW){err_r[EW-1]}}, err_r};
      agpid_pkg::B_DIFF: op_b = {{(B_W-EW-1){diff_r[EW]}}, diff_r};
      agpid_pkg::B_DIN:  op_b = din_r;
      agpid_pkg::B_SUM:  op_b = {{(B_W-32){sum_r[31]}}, sum_r};
      default:           op_b = din_r;
    endcase
  end

  // arithmetic shift rounds toward minus infinity
  assign prod_sh = prod_r >>> GAIN_FRAC_BITS;
  assign acc_hi  = acc_r > ACC_MAX;
  assign acc_lo  = acc_r < ACC_MIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      sum_r  <= '0;
    end else if (in_fire) begin
      prev_r <= err_in;
      sum_r  <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r  <= err_in;
      diff_r <= {err_in[EW-1], err_in} - {prev_r[EW-1], prev_r};
      hit_r  <= sum_ovf;
      acc_r  <= {{(ACC_W-GW){offset_r[GW-1]}}, offset_r};
    end else if (ctl.acc_add) begin
      acc_r  <= acc_r + {{(ACC_W-PROD_W){prod_sh[PROD_W-1]}}, prod_sh};
    end
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(op_a * op_b);
    end
    if (ctl.din_load) begin
      din_r <= prod_sh[B_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (ctl.emit && out_free) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      out_tuser <= hit_r | acc_hi | acc_lo;
      if (acc_hi) begin
        out_tdata <= 32'h7fff_ffff;
      end else if (acc_lo) begin
        out_tdata <= 32'h8000_0000;
      end else begin
        out_tdata <= acc_r[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: verif/drive_tracker_pkg.sv
// ---------------------------------------------------------------------------
// drive_tracker_pkg
// Mirrors the gains, offset, previous error and error sum of the controller,
// works out the drive word each accepted error sample should produce, and
// checks the drive words that come back, oldest first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package drive_tracker_pkg;

  localparam int     FRAC_BITS   = agpid_pkg::GAIN_FRAC_BITS_DEF;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] drive;
    logic               clipped;
  } drive_word_t;

  class drive_tracker;
    longint      kp_nonneg, kp_neg, kd, ki, offset;
    longint      prev_err, err_sum;
    drive_word_t drive_q[$];
    int          mismatches;
    int          words_seen;

    function new();
      kp_nonneg  = 0;
      kp_neg     = 0;
      kd         = 0;
      ki         = 0;
      offset     = 0;
      prev_err   = 0;
      err_sum    = 0;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void set_reg(logic [agpid_pkg::CFG_AW-1:0] addr,
                          logic [agpid_pkg::GAIN_W-1:0] val);
      longint v;
      v = $signed(val);
      case (addr)
        agpid_pkg::REG_GAIN_P_NONNEG: kp_nonneg = v;
        agpid_pkg::REG_GAIN_P_NEG:    kp_neg    = v;
        agpid_pkg::REG_GAIN_D:        kd        = v;
        agpid_pkg::REG_GAIN_I:        ki        = v;
        agpid_pkg::REG_DRIVE_OFFSET:  offset    = v;
        default: ;
      endcase
    endfunction

    function longint clip32(longint v, inout bit hit);
      if (v > S32_MAX) begin
        hit = 1'b1;
        return S32_MAX;
      end
      if (v < S32_MIN) begin
        hit = 1'b1;
        return S32_MIN;
      end
      return v;
    endfunction

    // one error sample in, one expected drive word queued
    function void take_error(logic signed [agpid_pkg::ERROR_WIDTH_DEF-1:0] e);
      longint      ev, kp, p, d_inner, d, integ, y;
      bit          hit;
      drive_word_t w;
      ev      = e;
      hit     = 1'b0;
      kp      = (ev >= 0) ? kp_nonneg : kp_neg;
      p       = (kp * ev) >>> FRAC_BITS;
      d_inner = (kd * (ev - prev_err)) >>> FRAC_BITS;
      d       = (kp * d_inner) >>> FRAC_BITS;
      err_sum = clip32(err_sum + ev, hit);
      integ   = (err_sum * ki) >>> FRAC_BITS;
      y       = clip32(p + d + integ + offset, hit);
      prev_err = ev;
      w.drive   = y[31:0];
      w.clipped = hit;
      drive_q.push_back(w);
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_drive(logic [31:0] drive, logic clipped);
      drive_word_t w;
      words_seen++;
      if (drive_q.size() == 0) begin
        report($sformatf("drive word %0d (%0d) arrived with none pending",
                         words_seen, $signed(drive)));
        return;
      end
      w = drive_q.pop_front();
      if (drive !== w.drive)
        report($sformatf("word %0d drive %0d, expected %0d",
                         words_seen, $signed(drive), w.drive));
      if (clipped !== w.clipped)
        report($sformatf("word %0d clipped %b, expected %b",
                         words_seen, clipped, w.clipped));
    endtask

    function int pending();
      return drive_q.size();
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Streams error samples into the asymmetric-gain PID controller under a
// series of gain settings, with random gaps on the input and random stalls
// on the output, and checks every drive word against a mirror of the
// controller. Covers the register extremes, ignored register indexes,
// drive saturation both ways and a wind-up of the error sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int ERROR_WIDTH     = agpid_pkg::ERROR_WIDTH_DEF;
  localparam int IN_TW           = ((ERROR_WIDTH + 7) / 8) * 8;
  localparam int NUM_REGS        = 5;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int WIND_ITEMS      = 32;
  localparam int SETTLE_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic signed [15:0] E_MAX = 16'sh7fff;
  localparam logic signed [15:0] E_MIN = 16'sh8000;

  typedef logic [agpid_pkg::CFG_AW-1:0] addr_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_we     = 1'b0;
  addr_t             cfg_addr   = '0;
  logic [agpid_pkg::GAIN_W-1:0] cfg_wdata = '0;

  drive_tracker_pkg::drive_tracker sb;
  bit                tx_gaps_on;
  bit                rx_stalls_on;
  logic signed [15:0] last_err;
  int                idle_cycles;

  always #1 clk = ~clk;

  asymmetric_gain_pid_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [15:0] error_sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [31:0] drive_value
    .out_tuser  (out_tuser),    // [0] clipped
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // handshakes are sampled with the values from before the edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.take_error(in_tdata[ERROR_WIDTH-1:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_drive(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_wait(bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023) - 512);
      2: begin
        case ($urandom_range(0, 4))
          0: return E_MAX;
          1: return E_MIN;
          2: return 16'sd0;
          3: return 16'sd256;
          default: return -16'sd256;
        endcase
      end
      default: return 16'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_error();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: last_err = 16'($urandom);
      4, 5: begin
        case ($urandom_range(0, 4))
          0: last_err = E_MAX;
          1: last_err = E_MIN;
          2: last_err = 16'sd0;
          3: last_err = 16'sd1;
          default: last_err = -16'sd1;
        endcase
      end
      6, 7, 8: last_err = 16'($urandom_range(0, 600) - 300);
      default: ;  // repeat the last sample, no derivative kick
    endcase
    return last_err;
  endfunction

  // tvalid stays up across back-to-back words
  task automatic push_error(input logic signed [15:0] e, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TW'(e);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input addr_t addr, input logic [agpid_pkg::GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(addr, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(input logic [15:0] kpp, input logic [15:0] kpn,
                           input logic [15:0] kd, input logic [15:0] ki,
                           input logic [15:0] off);
    write_reg(agpid_pkg::REG_GAIN_P_NONNEG, kpp);
    write_reg(agpid_pkg::REG_GAIN_P_NEG, kpn);
    write_reg(agpid_pkg::REG_GAIN_D, kd);
    write_reg(agpid_pkg::REG_GAIN_I, ki);
    write_reg(agpid_pkg::REG_DRIVE_OFFSET, off);
  endtask

  // result side: per-word random stall, tready kept up when no stall
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = draw_wait(rx_stalls_on);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    sb           = new();
    idle_cycles  = 0;
    last_err     = '0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: drive stays at zero
    push_error(16'sd0, draw_wait(tx_gaps_on));
    push_error(E_MAX, draw_wait(tx_gaps_on));
    push_error(E_MIN, draw_wait(tx_gaps_on));
    drain();

    // registers at their extremes (negative-error gain at the low one), full-swing error steps
    set_gains(E_MAX, E_MIN, E_MAX, E_MAX, E_MAX);
    push_error(E_MAX, draw_wait(tx_gaps_on));
    push_error(E_MIN, draw_wait(tx_gaps_on));
    push_error(E_MAX, draw_wait(tx_gaps_on));
    push_error(E_MIN, draw_wait(tx_gaps_on));
    push_error(16'sd0, draw_wait(tx_gaps_on));
    push_error(-16'sd1, draw_wait(tx_gaps_on));
    push_error(16'sd1, draw_wait(tx_gaps_on));
    drain();

    // the opposite extreme
    set_gains(E_MIN, E_MAX, E_MIN, E_MIN, E_MIN);
    push_error(E_MIN, draw_wait(tx_gaps_on));
    push_error(E_MAX, draw_wait(tx_gaps_on));
    push_error(E_MIN, draw_wait(tx_gaps_on));
    push_error(16'sd0, draw_wait(tx_gaps_on));
    push_error(16'sd1, draw_wait(tx_gaps_on));
    push_error(-16'sd1, draw_wait(tx_gaps_on));
    drain();

    // ordinary gains, then writes to unused indexes must not disturb them
    set_gains(16'sd256, 16'sd384, 16'sd64, 16'sd16, -16'sd100);
    for (int a = NUM_REGS; a < (1 << agpid_pkg::CFG_AW); a++)
      write_reg(addr_t'(a), 16'($urandom));
    push_error(16'sd1000, draw_wait(tx_gaps_on));
    push_error(-16'sd1000, draw_wait(tx_gaps_on));
    push_error(16'sd5, draw_wait(tx_gaps_on));
    push_error(-16'sd5, draw_wait(tx_gaps_on));
    push_error(16'sd0, draw_wait(tx_gaps_on));
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tx_gaps_on   = (ph % 4 == 0) || (ph % 4 == 1);
      rx_stalls_on = (ph % 4 == 0) || (ph % 4 == 2);
      set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain());
      repeat (ITEMS_PER_PHASE) push_error(pick_error(), draw_wait(tx_gaps_on));
      drain();
    end

    // wind the error sum down at full rate
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    set_gains(16'sd256, 16'sd320, 16'sd128, E_MAX, 16'sd0);
    repeat (WIND_ITEMS) push_error(E_MIN, 0);
    drain();

    // flip the integral gain, then reverse the error
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    write_reg(agpid_pkg::REG_GAIN_I, E_MIN);
    repeat (6) push_error(E_MIN, draw_wait(tx_gaps_on));
    repeat (6) push_error(E_MAX, draw_wait(tx_gaps_on));
    drain();

    if (sb.pending() != 0)
      sb.report($sformatf("%0d drive words never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: asymmetric_gain_pid_controller.f
rtl/agpid_pkg.sv
rtl/asymmetric_gain_pid_controller.sv
verif/drive_tracker_pkg.sv
verif/tb_top.sv
